// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the top level of the sorted set block.
// Holds macro definitions only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SISD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SISD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sisd_pkg.sv =====
// Types and constants of the sorted set block.
// No dependencies; imported by sisd_cell and sorted_set_insert_delete.
package sisd_pkg;

	localparam int CAPACITY = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int MODE_W   = 2;
	localparam int STAT_W   = 3;

	// Stream widths, rounded up to whole bytes
	localparam int S_TDATA_W = ((MODE_W + VAL_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((STAT_W + VAL_W + 7) / 8) * 8;

	// Request modes
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd2;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_INSERTED   = 3'd0,
		ST_DUPLICATE  = 3'd1,
		ST_REMOVED    = 3'd2,
		ST_NOT_FOUND  = 3'd3,
		ST_FULL       = 3'd4,
		ST_DUMP_ENTRY = 3'd5,
		ST_DUMP_EMPTY = 3'd6
	} status_t;

	// Broadcast control from the sequencer to every cell
	typedef struct packed {
		logic                    cmp;  // register compare flags against val
		logic                    ins;  // insert val at its sorted place
		logic                    del;  // close the gap at the matching entry
		logic                    rot;  // rotate one place towards cell 0
		logic signed [VAL_W-1:0] val;  // request value
	} cell_ctl_t;

endpackage

// ===== rtl/sisd_cell.sv =====
// One cell of the sorted chain: a stored value plus its compare flags.
// Depends on sisd_pkg.
module sisd_cell (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  sisd_pkg::cell_ctl_t                   ctl,
	input  logic                                  occ,        // cell holds a live entry
	input  logic                                  left_shift, // left neighbour moves in
	input  logic signed [sisd_pkg::VAL_W-1:0]     left_val,
	input  logic signed [sisd_pkg::VAL_W-1:0]     right_val,
	output logic signed [sisd_pkg::VAL_W-1:0]     val,
	output logic                                  gt,         // val above request
	output logic                                  eq          // val equals request
);
	import sisd_pkg::*;

	logic signed [VAL_W-1:0] val_q;
	logic                    gt_q;
	logic                    eq_q;
	logic signed [VAL_W-1:0] val_nxt;

	// Next value: shift right on insert, shift left on delete or rotate
	always_comb begin
		val_nxt = val_q;
		if (ctl.ins) begin
			if (left_shift)
				val_nxt = left_val;
			else if (gt_q || !occ)
				val_nxt = ctl.val;
		end else if (ctl.del) begin
			if (occ && (gt_q || eq_q))
				val_nxt = right_val;
		end else if (ctl.rot) begin
			val_nxt = right_val;
		end
	end

	// Stored value, no reset
	always_ff @(posedge clk) begin
		val_q <= val_nxt;
	end

	// Compare flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctl.cmp) begin
			gt_q <= (val_q > ctl.val);
			eq_q <= (val_q == ctl.val);
		end
	end

	assign val = val_q;
	assign gt  = gt_q;
	assign eq  = eq_q;

endmodule

// ===== rtl/sorted_set_insert_delete.sv =====
// Top level of the sorted set: sequencer, output register and the cell chain.
// Depends on sisd_pkg, sisd_cell and assert_macros.svh.
//
// Usage:
//  Slave channel (s_*) takes requests: insert, delete or dump a set of
//  distinct signed 32-bit values held in ascending order, up to CAPACITY.
//  Master channel (m_*) gives results; m_tlast marks the final beat of the
//  results caused by one request.
//  Insert and delete give one status beat. A dump gives one beat per stored
//  value, lowest first, or a single dump-empty beat when the set is empty.
//  Sequence: a request first registers the compare flags in every cell
//  (S_CMP), then applies the shift (S_EXEC); the next request can be taken
//  in the apply step when the output register is free. The result sits in
//  the output register from the cycle after the apply cycle. A dump passes
//  the two request steps, enters the rotation (S_DUMP), then gives one beat
//  per entry as the chain rotates one place per beat past cell 0; the next
//  request is taken the cycle after the last beat is loaded. An empty dump
//  and mode three end after the apply step; mode three gives nothing.
//  When the receiver stalls, the block holds in its apply or dump step until
//  the output register frees up; the set is not touched meanwhile.
//  Reset empties the set at once; no clearing pass is needed.
`include "assert_macros.svh"

module sorted_set_insert_delete (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [sisd_pkg::S_TDATA_W-1:0]     s_tdata,  // mode[1:0], value[33:2]
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [sisd_pkg::M_TDATA_W-1:0]     m_tdata,  // status[2:0], stored_value[34:3]
	output logic                               m_tlast
);
	import sisd_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_EXEC,
		S_DUMP
	} state_t;

	state_t                  state_q;
	logic [MODE_W-1:0]       req_mode_q;
	logic signed [VAL_W-1:0] req_val_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        dump_idx_q;
	logic                    out_valid_q;
	status_t                 out_status_q;
	logic signed [VAL_W-1:0] out_val_q;
	logic                    out_last_q;

	cell_ctl_t               ctl;
	logic signed [VAL_W-1:0] vals  [CAPACITY];
	logic signed [VAL_W-1:0] lvals [CAPACITY];
	logic signed [VAL_W-1:0] rvals [CAPACITY];
	logic [CAPACITY-1:0]     occ;
	logic [CAPACITY-1:0]     gts;
	logic [CAPACITY-1:0]     eqs;
	logic [CAPACITY-1:0]     lshift;

	logic out_load;
	logic out_fire;
	logic hit;
	logic full;
	logic accept;
	logic dump_last;

	// Cell chain with neighbour wiring
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign occ[i] = (CNT_W'(i) < count_q);
		if (i == 0) begin : g_head
			assign lshift[i] = 1'b0;
			assign lvals[i]  = req_val_q;
		end else begin : g_body
			assign lshift[i] = occ[i-1] & gts[i-1];
			assign lvals[i]  = vals[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign rvals[i] = vals[0];
		end else begin : g_mid
			assign rvals[i] = (CNT_W'(i + 1) == count_q) ? vals[0] : vals[i+1];
		end

		sisd_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.occ        (occ[i]),
			.left_shift (lshift[i]),
			.left_val   (lvals[i]),
			.right_val  (rvals[i]),
			.val        (vals[i]),
			.gt         (gts[i]),
			.eq         (eqs[i])
		);
	end

	// Set-wide flags
	assign out_load  = !out_valid_q || m_tready;
	assign hit       = |(occ & eqs);
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign dump_last = ((dump_idx_q + CNT_W'(1)) == count_q);
	assign accept    = s_tvalid && s_tready;

	// Output register takes a new beat this cycle
	assign out_fire = out_load && ((state_q == S_DUMP) || ((state_q == S_EXEC)
		&& ((req_mode_q inside {MODE_INSERT, MODE_DELETE})
		|| ((req_mode_q == MODE_DUMP) && (count_q == '0)))));

	// Request acceptance
	always_comb begin
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: s_tready = 1'b1;
			S_EXEC: begin
				case (req_mode_q)
					MODE_INSERT, MODE_DELETE: s_tready = out_load;
					MODE_DUMP:                s_tready = out_load && (count_q == '0);
					default:                  s_tready = 1'b1;
				endcase
			end
			default: s_tready = 1'b0;
		endcase
	end

	// Broadcast control to the cells
	always_comb begin
		ctl     = '0;
		ctl.val = req_val_q;
		ctl.cmp = (state_q == S_CMP);
		ctl.ins = (state_q == S_EXEC) && (req_mode_q == MODE_INSERT) && !hit && !full
			&& out_load;
		ctl.del = (state_q == S_EXEC) && (req_mode_q == MODE_DELETE) && hit && out_load;
		ctl.rot = (state_q == S_DUMP) && out_load;
	end

	// Sequencer, fill count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			req_mode_q   <= MODE_INSERT;
			req_val_q    <= '0;
			count_q      <= '0;
			dump_idx_q   <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_INSERTED;
			out_val_q    <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_fire)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			if (accept) begin
				req_mode_q <= s_tdata[MODE_W-1:0];
				req_val_q  <= s_tdata[MODE_W +: VAL_W];
			end
			case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_CMP;
				end
				S_CMP: state_q <= S_EXEC;
				S_EXEC: begin
					case (req_mode_q)
						MODE_INSERT: begin
							if (out_load) begin
								out_val_q   <= req_val_q;
								out_last_q  <= 1'b1;
								if (hit)
									out_status_q <= ST_DUPLICATE;
								else if (full)
									out_status_q <= ST_FULL;
								else begin
									out_status_q <= ST_INSERTED;
									count_q      <= count_q + CNT_W'(1);
								end
								state_q <= accept ? S_CMP : S_IDLE;
							end
						end
						MODE_DELETE: begin
							if (out_load) begin
								out_val_q   <= req_val_q;
								out_last_q  <= 1'b1;
								if (hit) begin
									out_status_q <= ST_REMOVED;
									count_q      <= count_q - CNT_W'(1);
								end else
									out_status_q <= ST_NOT_FOUND;
								state_q <= accept ? S_CMP : S_IDLE;
							end
						end
						MODE_DUMP: begin
							if (count_q == '0) begin
								if (out_load) begin
									out_status_q <= ST_DUMP_EMPTY;
									out_val_q    <= req_val_q;
									out_last_q   <= 1'b1;
									state_q      <= accept ? S_CMP : S_IDLE;
								end
							end else begin
								dump_idx_q <= '0;
								state_q    <= S_DUMP;
							end
						end
						default: state_q <= accept ? S_CMP : S_IDLE;
					endcase
				end
				S_DUMP: begin
					// cell 0 leaves, chain rotates one place
					if (out_load) begin
						out_status_q <= ST_DUMP_ENTRY;
						out_val_q    <= vals[0];
						out_last_q   <= dump_last;
						dump_idx_q   <= dump_idx_q + CNT_W'(1);
						if (dump_last)
							state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output port
	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(M_TDATA_W - STAT_W - VAL_W){1'b0}}, out_val_q, out_status_q};

	// Checks
	`SISD_ASSERT(a_count_range, count_q <= CNT_W'(CAPACITY), "fill count above capacity")
	`SISD_ASSERT_NEXT(a_count_stall, out_valid_q && !m_tready, $stable(count_q), "set changed")
	`SISD_ASSERT_NEXT(a_dump_bound, state_q == S_DUMP, dump_idx_q <= count_q, "dump overran")
	`SISD_ASSERT(a_no_take_busy, !(s_tready && (state_q == S_CMP || state_q == S_DUMP)), "busy")

endmodule
